>>> rtl/cst_pkg.sv
// Shared types, token kind codes and character helpers for the stream tokenizer.
`default_nettype none

package cst_pkg;

  localparam logic [3:0] KIND_EOL       = 4'd0;
  localparam logic [3:0] KIND_EOF       = 4'd1;
  localparam logic [3:0] KIND_KEYWORD   = 4'd2;
  localparam logic [3:0] KIND_IDENT     = 4'd3;
  localparam logic [3:0] KIND_LITERAL   = 4'd4;
  localparam logic [3:0] KIND_COMMENT   = 4'd5;
  localparam logic [3:0] KIND_SEPARATOR = 4'd6;
  localparam logic [3:0] KIND_OPERATOR  = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd8;
  localparam logic [3:0] KIND_NONE      = 4'd0;  // kind on open-token text words

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [2:0] WORD_LEN_MAX    = 3'd7;
  localparam logic [2:0] FUNC_LEN        = 3'd4;
  localparam logic [2:0] RETURN_LEN      = 3'd6;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_WORD    = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_COMMENT = 5'b10000
  } cst_mode_t;

  // one result word
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text;
    logic       has_text;
    logic       token_end;
  } cst_res_t;

  // everything one input word produces: one or two results
  typedef struct packed {
    logic     two;
    cst_res_t first;
    cst_res_t second;
  } cst_entry_t;

  function automatic cst_res_t mk_res(logic [3:0] kind, logic [7:0] text,
                                      logic has_text, logic token_end);
    cst_res_t r;
    r.kind      = kind;
    r.text      = text;
    r.has_text  = has_text;
    r.token_end = token_end;
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_break(logic [7:0] c);
    return ((c < 8'h20) || (c == 8'h7F)) && (c != 8'h09);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h3D) || (c == 8'h2A) || (c == 8'h21);
  endfunction

  function automatic logic [7:0] func_char(logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h66; // f
      2'd1:    c = 8'h75; // u
      2'd2:    c = 8'h6E; // n
      default: c = 8'h63; // c
    endcase
    return c;
  endfunction

  function automatic logic [7:0] return_char(logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h72; // r
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h75; // u
      3'd4:    c = 8'h72; // r
      3'd5:    c = 8'h6E; // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // drop keyword candidates that no longer match at position p
  function automatic logic [1:0] feed_match(logic [1:0] km, logic [2:0] p, logic [7:0] c);
    logic [1:0] m;
    m = km;
    if ((p >= FUNC_LEN) || (func_char(p[1:0]) != c)) m[0] = 1'b0;
    if ((p >= RETURN_LEN) || (return_char(p) != c)) m[1] = 1'b0;
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/char_stream_tokenizer_top.sv
// Top level of the byte-stream tokenizer: front end, entry queue and back end.
//
//  channel | dir | signals                          | payload
//  --------+-----+----------------------------------+--------------------------------------
//  in_     | in  | tvalid tready tdata[7:0] tlast   | tdata: text_byte; tlast: end_of_input
//  out_    | out | tvalid tready tdata[7:0] tuser[5:0] tlast | tdata: out_byte;
//          |     |                                  | tuser: kind[3:0] has_text token_end;
//          |     |                                  | tlast: last
//
// One input word is taken per cycle; its zero to two results enter the queue in
// the same cycle. The back end sends one result word per cycle while out_tready
// is high, so a word that yields two results holds the back end for both words
// and the queue absorbs the difference until it fills and in_tready drops.
// Synchronous active-low reset returns the scanner to idle and empties the
// queue and output register.
`default_nettype none

module char_stream_tokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [5:0]      out_tuser,  // [3:0] kind, [4] has_text, [5] token_end
  output logic            out_tlast
);
  import cst_pkg::*;

  logic       q_push, q_full, q_pop, q_not_empty;
  cst_entry_t q_entry, q_head;

  cst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  cst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  cst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/cst_front.sv
// Front end: takes source bytes, tracks the scan mode and builds result entries.
`default_nettype none

module cst_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tlast,
  input  wire logic              q_full,
  output logic                   q_push,
  output cst_pkg::cst_entry_t    q_entry
);
  import cst_pkg::*;

  cst_mode_t   mode_r, mode_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [1:0]  km_r, km_nxt;
  logic        accept;
  logic [7:0]  c;
  logic [3:0]  close_kind;
  logic [1:0]  nres;
  cst_res_t    r0, r1;
  cst_res_t    close_res, eol_res;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  always_comb begin
    close_kind = KIND_LITERAL;
    if (mode_r == MODE_WORD) begin
      if ((km_r[0] && (len_r == FUNC_LEN)) || (km_r[1] && (len_r == RETURN_LEN)))
        close_kind = KIND_KEYWORD;
      else
        close_kind = KIND_IDENT;
    end else if (mode_r == MODE_COMMENT) begin
      close_kind = KIND_COMMENT;
    end
  end

  assign close_res = mk_res(close_kind, 8'h00, 1'b0, 1'b1);
  assign eol_res   = mk_res(KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1);

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    km_nxt   = km_r;
    nres     = 2'd0;
    r0       = '0;
    r1       = '0;
    if (in_tlast) begin
      if ((mode_r == MODE_WORD) || (mode_r == MODE_NUMBER) ||
          (mode_r == MODE_STRING) || (mode_r == MODE_COMMENT)) begin
        nres = 2'd2;
        r0   = close_res;
        r1   = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
      end else begin
        nres = 2'd1;
        r0   = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
      end
      mode_nxt = MODE_IDLE;
      len_nxt  = 3'd0;
      km_nxt   = 2'b11;
    end else begin
      unique case (mode_r) inside
        MODE_WORD, MODE_NUMBER: begin
          if (is_blank(c) || is_break(c)) begin
            nres     = is_break(c) ? 2'd2 : 2'd1;
            r0       = close_res;
            r1       = eol_res;
            mode_nxt = MODE_IDLE;
            len_nxt  = 3'd0;
            km_nxt   = 2'b11;
          end else begin
            nres = 2'd1;
            r0   = mk_res(KIND_NONE, c, 1'b1, 1'b0);
            if (mode_r == MODE_WORD) begin
              km_nxt  = feed_match(km_r, len_r, c);
              len_nxt = (len_r == WORD_LEN_MAX) ? len_r : len_r + 3'd1;
            end
          end
        end
        MODE_STRING: begin
          nres = 2'd1;
          if (c == CHAR_QUOTE) begin
            r0       = close_res;
            mode_nxt = MODE_IDLE;
            len_nxt  = 3'd0;
            km_nxt   = 2'b11;
          end else begin
            r0 = mk_res(KIND_NONE, c, 1'b1, 1'b0);
          end
        end
        MODE_COMMENT: begin
          if (is_break(c)) begin
            nres     = 2'd2;
            r0       = close_res;
            r1       = eol_res;
            mode_nxt = MODE_IDLE;
            len_nxt  = 3'd0;
            km_nxt   = 2'b11;
          end else begin
            nres = 2'd1;
            r0   = mk_res(KIND_NONE, c, 1'b1, 1'b0);
          end
        end
        default: begin
          // idle, and any stray mode code falls back to idle
          mode_nxt = MODE_IDLE;
          if (is_blank(c)) begin
            nres = 2'd0;
          end else if (is_break(c)) begin
            nres = 2'd1;
            r0   = eol_res;
          end else if (is_alpha(c)) begin
            nres     = 2'd1;
            r0       = mk_res(KIND_NONE, c, 1'b1, 1'b0);
            mode_nxt = MODE_WORD;
            km_nxt   = feed_match(2'b11, 3'd0, c);
            len_nxt  = 3'd1;
          end else if (is_digit(c)) begin
            nres     = 2'd1;
            r0       = mk_res(KIND_NONE, c, 1'b1, 1'b0);
            mode_nxt = MODE_NUMBER;
          end else if (c == CHAR_SLASH) begin
            nres     = 2'd1;
            r0       = mk_res(KIND_NONE, c, 1'b1, 1'b0);
            mode_nxt = MODE_COMMENT;
          end else if (c == CHAR_QUOTE) begin
            nres     = 2'd0;
            mode_nxt = MODE_STRING;
          end else if (is_sep(c)) begin
            nres = 2'd1;
            r0   = mk_res(KIND_SEPARATOR, c, 1'b1, 1'b1);
          end else if (is_op(c)) begin
            nres = 2'd1;
            r0   = mk_res(KIND_OPERATOR, c, 1'b1, 1'b1);
          end else begin
            nres = 2'd1;
            r0   = mk_res(KIND_UNKNOWN, CHAR_QMARK, 1'b1, 1'b1);
          end
        end
      endcase
    end
  end

  assign q_push        = accept && (nres != 2'd0);
  assign q_entry.two   = (nres == 2'd2);
  assign q_entry.first = r0;
  assign q_entry.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= 3'd0;
      km_r   <= 2'b11;
    end else if (accept) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      km_r   <= km_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cst_queue.sv
// Small FIFO of result entries between the front and back ends.
`default_nettype none

module cst_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire cst_pkg::cst_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output cst_pkg::cst_entry_t      head
);
  import cst_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cst_entry_t     mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cst_back.sv
// Back end: unpacks queue entries into one result word per cycle while out_tready allows, behind an output register.
`default_nettype none

module cst_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire cst_pkg::cst_entry_t q_head,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,
  output logic [5:0]               out_tuser,
  output logic                     out_tlast
);
  import cst_pkg::*;

  logic      valid_r;
  logic      second_r;   // next word comes from the second slot of the head entry
  cst_res_t  res_r;
  logic      last_r;
  logic      load;
  cst_res_t  sel;
  logic      sel_last;

  assign load     = q_not_empty && (!valid_r || out_tready);
  assign sel      = second_r ? q_head.second : q_head.first;
  assign sel_last = second_r || !q_head.two;
  assign q_pop    = load && sel_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        second_r <= !sel_last;
      end else if (out_tready) begin
        valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= sel;
      last_r <= sel_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.text;
  assign out_tuser  = {res_r.token_end, res_r.has_text, res_r.kind};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

>>> tb/tb_char_stream_tokenizer_top.sv
// Self-checking testbench for the byte-stream tokenizer: directed table, random token streams.
module tb_char_stream_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_ITEMS = 1950;
  localparam int          DRAIN_CYCLES = 32;
  localparam logic [31:0] FUNC_TXT     = "func";
  localparam logic [47:0] RETURN_TXT   = "return";

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text;
    logic       has_text;
    logic       token_end;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } src_word_t;

  // typed_n < 0: take the expectation from the predictor
  typedef struct {
    logic [7:0] b;
    logic       eoi;
    int         typed_n;
    tok_t       r0;
    tok_t       r1;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;
  logic       out_tlast;

  char_stream_tokenizer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  tok_t        token_q[$];
  src_word_t   frag_q[$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;
  string       single_set = "()+-=*!#$%&,.:;<>?@[]^_{|}~";

  // scanner state kept by the predictor
  cst_mode_t   scan_st = MODE_IDLE;
  logic [47:0] word_tail = '0;
  int          word_cnt = 0;
  tok_t        tok_buf[2];
  int          tok_cnt;
  logic        idle_blank;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic blank_ch(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic break_ch(logic [7:0] c);
    return (c <= 8'h1F && c != 8'h09) || (c == 8'h7F);
  endfunction

  function automatic logic [3:0] closing_kind();
    if (scan_st == MODE_WORD) begin
      if ((word_cnt == 4 && word_tail[31:0] == FUNC_TXT) ||
          (word_cnt == 6 && word_tail == RETURN_TXT))
        return KIND_KEYWORD;
      return KIND_IDENT;
    end
    if (scan_st == MODE_COMMENT) return KIND_COMMENT;
    return KIND_LITERAL;
  endfunction

  function automatic void put_tok(logic [3:0] k, logic [7:0] b, logic t, logic e);
    tok_buf[tok_cnt] = '{k, b, t, e, 1'b0};
    tok_cnt++;
  endfunction

  function automatic void close_open();
    put_tok(closing_kind(), 8'h00, 1'b0, 1'b1);
    scan_st = MODE_IDLE;
  endfunction

  // advance the scanner by one input word and collect its results in tok_buf
  function automatic void tokenize_byte(logic [7:0] c, logic eoi);
    tok_cnt = 0;
    idle_blank = 1'b0;
    if (eoi) begin
      if (scan_st != MODE_IDLE) close_open();
      put_tok(KIND_EOF, 8'h00, 1'b0, 1'b1);
    end else begin
      case (scan_st)
        MODE_IDLE: begin
          if (blank_ch(c)) begin
            idle_blank = 1'b1;
          end else if (break_ch(c)) begin
            put_tok(KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1);
          end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            scan_st = MODE_WORD;
            word_tail = {40'h0, c};
            word_cnt = 1;
            put_tok(KIND_NONE, c, 1'b1, 1'b0);
          end else if (c >= "0" && c <= "9") begin
            scan_st = MODE_NUMBER;
            put_tok(KIND_NONE, c, 1'b1, 1'b0);
          end else if (c == CHAR_SLASH) begin
            scan_st = MODE_COMMENT;
            put_tok(KIND_NONE, c, 1'b1, 1'b0);
          end else if (c == CHAR_QUOTE) begin
            scan_st = MODE_STRING;
          end else if (c == "(" || c == ")") begin
            put_tok(KIND_SEPARATOR, c, 1'b1, 1'b1);
          end else if (c == "+" || c == "-" || c == "=" || c == "*" || c == "!") begin
            put_tok(KIND_OPERATOR, c, 1'b1, 1'b1);
          end else begin
            put_tok(KIND_UNKNOWN, CHAR_QMARK, 1'b1, 1'b1);
          end
        end
        MODE_STRING: begin
          if (c == CHAR_QUOTE) close_open();
          else put_tok(KIND_NONE, c, 1'b1, 1'b0);
        end
        MODE_COMMENT: begin
          if (break_ch(c)) begin
            close_open();
            put_tok(KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1);
          end else begin
            put_tok(KIND_NONE, c, 1'b1, 1'b0);
          end
        end
        default: begin
          if (blank_ch(c)) begin
            close_open();
          end else if (break_ch(c)) begin
            close_open();
            put_tok(KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1);
          end else begin
            if (scan_st == MODE_WORD) begin
              word_tail = {word_tail[39:0], c};
              if (word_cnt < 7) word_cnt++;
            end
            put_tok(KIND_NONE, c, 1'b1, 1'b0);
          end
        end
      endcase
    end
    if (tok_cnt > 0) tok_buf[tok_cnt-1].last = 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_break();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return 8'h7F;
    do b = 8'($urandom_range(0, 31)); while (b == 8'h09);
    return b;
  endfunction

  function automatic void push_w(logic [7:0] b, logic eoi);
    src_word_t sw;
    sw = '{b, eoi};
    frag_q = {frag_q, sw};
  endfunction

  function automatic void expect_tok(tok_t t);
    token_q = {token_q, t};
  endfunction

  function automatic void push_delim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) push_w(8'h20, 1'b0);
    else if (r < 65) push_w(8'h09, 1'b0);
    else if (r < 80) push_w(CHAR_NEWLINE, 1'b0);
    else if (r < 88) push_w(rand_break(), 1'b0);
    else if (r >= 95) push_w(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // one random fragment of source text: mostly well-formed tokens, some noise
  function automatic void build_fragment();
    int         sel;
    int         n;
    int         cut;
    int         mut;
    int         r;
    logic [7:0] b;
    string      kw;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) push_w(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else if (sel < 30) begin
      push_w(rand_letter(), 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 60) b = rand_letter();
        else if (r < 85) b = 8'h30 + 8'($urandom_range(0, 9));
        else b = 8'($urandom_range(33, 126));
        push_w(b, 1'b0);
      end
      push_delim();
    end else if (sel < 42) begin
      // keywords and near misses
      if ($urandom_range(0, 1) != 0) kw = "func";
      else kw = "return";
      n = kw.len();
      cut = $urandom_range(0, 9);
      mut = $urandom_range(0, n - 1);
      if (cut == 9) push_w(rand_letter(), 1'b0);
      for (int i = 0; i < n; i++) begin
        if (!(cut == 6 && i == n - 1))
          push_w((cut == 8 && i == mut) ? rand_letter() : kw[i], 1'b0);
      end
      if (cut == 7) repeat ($urandom_range(1, 2)) push_w(rand_letter(), 1'b0);
      push_delim();
    end else if (sel < 52) begin
      push_w(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) push_w(rand_letter(), 1'b0);
        else push_w(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      end
      push_delim();
    end else if (sel < 64) begin
      push_w(CHAR_QUOTE, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE);
        push_w(b, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) push_w(CHAR_QUOTE, 1'b0);
      else push_w(8'($urandom_range(0, 255)), 1'b1);
    end else if (sel < 74) begin
      push_w(CHAR_SLASH, 1'b0);
      n = $urandom_range(0, 10);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255)); while (break_ch(b));
        push_w(b, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) push_w(rand_break(), 1'b0);
      else push_w(8'($urandom_range(0, 255)), 1'b1);
    end else if (sel < 90) begin
      push_w(single_set[$urandom_range(0, single_set.len() - 1)], 1'b0);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        r = $urandom_range(0, 3);
        if (r == 0) push_w(8'h20, 1'b0);
        else if (r == 1) push_w(8'h09, 1'b0);
        else push_w(rand_break(), 1'b0);
      end
    end
  endfunction

  // offer one word, predict its results once the handshake is certain
  task automatic drive_word(input logic [7:0] b, input logic eoi, input int typed_n,
                            input tok_t t0, input tok_t t1);
    int   g;
    logic fired;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoi;
    do begin
      @(negedge clk);
      fired = (in_tready === 1'b1);
      if (fired) begin
        tokenize_byte(b, eoi);
        if (typed_n >= 0) begin
          if (typed_n > 0) expect_tok(t0);
          if (typed_n > 1) expect_tok(t1);
        end else begin
          for (int i = 0; i < tok_cnt; i++) expect_tok(tok_buf[i]);
        end
      end
      @(posedge clk);
    end while (!fired);
  endtask

  function automatic void check_result(tok_t got);
    tok_t want;
    if (token_q.size() == 0) begin
      $error("result with nothing expected: kind %0d byte %02h", got.kind, got.text);
      err_cnt++;
      return;
    end
    want = token_q.pop_front();
    if (got.kind != want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      err_cnt++;
    end
    if (got.text != want.text) begin
      $error("out_byte: expected %02h, got %02h", want.text, got.text);
      err_cnt++;
    end
    if (got.has_text != want.has_text) begin
      $error("has_text: expected %0d, got %0d", want.has_text, got.has_text);
      err_cnt++;
    end
    if (got.token_end != want.token_end) begin
      $error("token_end: expected %0d, got %0d", want.token_end, got.token_end);
      err_cnt++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      err_cnt++;
    end
  endfunction

  // sample at the falling edge, score after the rising edge that moves the word
  initial begin
    tok_t got;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got.kind      = out_tuser[3:0];
        got.text      = out_tdata;
        got.has_text  = out_tuser[4];
        got.token_end = out_tuser[5];
        got.last      = out_tlast;
        @(posedge clk);
        check_result(got);
      end
    end
  end

  initial begin
    int g;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      g = gap_len();
      if (g != 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("char_stream_tokenizer_top regression: fail");
    $finish;
  end

  initial begin
    dir_row_t  dir_tab[25];
    src_word_t w;
    int        items;
    int        next_pause;
    dir_tab = '{
      '{8'h00, 1'b0, 1, '{KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1, 1'b1}, '0},
      '{8'h20, 1'b0, 0, '0, '0},
      '{8'h09, 1'b0, 0, '0, '0},
      '{8'hFF, 1'b0, 1, '{KIND_UNKNOWN, CHAR_QMARK, 1'b1, 1'b1, 1'b1}, '0},
      '{8'h7F, 1'b0, 1, '{KIND_EOL, CHAR_NEWLINE, 1'b1, 1'b1, 1'b1}, '0},
      '{"(",   1'b0, 1, '{KIND_SEPARATOR, "(", 1'b1, 1'b1, 1'b1}, '0},
      '{")",   1'b0, 1, '{KIND_SEPARATOR, ")", 1'b1, 1'b1, 1'b1}, '0},
      '{"+",   1'b0, 1, '{KIND_OPERATOR, "+", 1'b1, 1'b1, 1'b1}, '0},
      '{"!",   1'b0, 1, '{KIND_OPERATOR, "!", 1'b1, 1'b1, 1'b1}, '0},
      // keyword closed by a line break
      '{"f",   1'b0, -1, '0, '0},
      '{"u",   1'b0, -1, '0, '0},
      '{"n",   1'b0, -1, '0, '0},
      '{"c",   1'b0, -1, '0, '0},
      '{8'h0A, 1'b0, -1, '0, '0},
      // number closed by a blank
      '{"9",   1'b0, -1, '0, '0},
      '{8'h20, 1'b0, -1, '0, '0},
      // empty string
      '{CHAR_QUOTE, 1'b0, -1, '0, '0},
      '{CHAR_QUOTE, 1'b0, -1, '0, '0},
      // comment with a tab inside, closed by a control byte
      '{CHAR_SLASH, 1'b0, -1, '0, '0},
      '{8'h09, 1'b0, -1, '0, '0},
      '{8'h1F, 1'b0, -1, '0, '0},
      // string left open at end of input
      '{CHAR_QUOTE, 1'b0, -1, '0, '0},
      '{"a",   1'b0, -1, '0, '0},
      '{8'h00, 1'b1, -1, '0, '0},
      '{8'hFF, 1'b1, 1, '{KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1}, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      drive_word(dir_tab[i].b, dir_tab[i].eoi, dir_tab[i].typed_n, dir_tab[i].r0,
                 dir_tab[i].r1);

    items = 0;
    next_pause = 450;
    while (items < RANDOM_ITEMS) begin
      no_gaps = ((items / 250) % 4 == 2);
      build_fragment();
      while (frag_q.size() != 0) begin
        w = frag_q.pop_front();
        drive_word(w.b, w.eoi, -1, '0, '0);
        if (!idle_blank) items++;
      end
      if (items >= next_pause) begin
        // hold the input until the queue of pending results has drained
        in_tvalid <= 1'b0;
        do @(posedge clk); while (token_q.size() != 0);
        next_pause += 450;
      end
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("char_stream_tokenizer_top regression: pass");
    end else begin
      $display("char_stream_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule
